// File: rtl/core/mcr_pkg.sv
// Shared constants and types for the midpoint circle rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcr_pkg;

    // Default width of the octant point coordinates
    localparam int COORD_WIDTH_DEF = 12;
    // Fixed field widths
    localparam int DEC_W    = 14;
    localparam int PIX_W    = 13;
    localparam int CTR_W    = 11;
    localparam int RAD_W    = 10;
    localparam int STRIDE_W = 4;
    localparam int OCT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd3;

    // Final octant of a point
    localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

    // Reset value of the stride register
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd1;

    // Live configuration
    typedef struct packed {
        logic [CTR_W-1:0]    center_x;
        logic [CTR_W-1:0]    center_y;
        logic [RAD_W-1:0]    radius;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// File: rtl/core/mcr_queue.sv
// Short register queue carrying point jobs from front to back.
// Depends on mcr_pkg for the depth.
`default_nettype none

module mcr_queue
    import mcr_pkg::*;
#(
    parameter int W = 25
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output t_q_status         o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;

    // pointer wrap at the queue depth
    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    assign o_status.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr = i_push ? f_inc(r_wptr) : r_wptr;
        n_rptr = i_pop  ? f_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mcr_front.sv
// Front end: takes restart/advance items, holds the octant point and
// decision, and queues one job per advance while active. Depends on mcr_pkg.
`default_nettype none

module mcr_front
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_restart,
    output logic                            o_in_stall,
    input  wire t_cfg                       i_cfg,
    input  wire t_q_status                  i_q_status,
    output logic                            o_push,
    output logic      [2*COORD_WIDTH:0]     o_job
);

    logic signed [COORD_WIDTH-1:0] r_x, n_x;
    logic signed [COORD_WIDTH-1:0] r_y, n_y;
    logic signed [DEC_W-1:0]       r_p, n_p;
    logic                          r_active, n_active;

    logic                          accept;
    logic signed [COORD_WIDTH-1:0] step;
    logic signed [COORD_WIDTH-1:0] adv_x;
    logic signed [COORD_WIDTH-1:0] adv_y;
    logic signed [DEC_W-1:0]       ext_x;
    logic signed [DEC_W-1:0]       ext_y;
    logic signed [DEC_W-1:0]       p_mid;
    logic signed [DEC_W-1:0]       adv_p;
    logic                          fin;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    // one midpoint step by the stride
    always_comb begin
        step  = COORD_WIDTH'(i_cfg.stride);
        adv_y = r_p[DEC_W-1] ? r_y : (r_y - step);
        ext_y = DEC_W'(adv_y);
        p_mid = r_p[DEC_W-1] ? r_p : (r_p - {ext_y[DEC_W-2:0], 1'b0});
        adv_x = r_x + step;
        ext_x = DEC_W'(adv_x);
        adv_p = p_mid + {ext_x[DEC_W-2:0], 1'b0} + DEC_W'(1);
        fin   = (adv_y < adv_x);
    end

    // job goes out with the point before the step
    assign o_push = accept && !i_restart && r_active;
    assign o_job  = {r_x, r_y, fin};

    // state update
    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_p      = r_p;
        n_active = r_active;
        if (accept) begin
            if (i_restart) begin
                n_x      = '0;
                n_y      = COORD_WIDTH'(i_cfg.radius);
                n_p      = DEC_W'(1) - DEC_W'(i_cfg.radius);
                n_active = 1'b1;
            end else if (r_active) begin
                n_x = adv_x;
                n_y = adv_y;
                n_p = adv_p;
                if (fin) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_p      <= '0;
            r_active <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_p      <= n_p;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mcr_back.sv
// Back end: expands the queued point into eight mirrored pixels, one per
// cycle while the output is not stalled, through a single output register. Depends on mcr_pkg.
`default_nettype none

module mcr_back
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_q_status              i_q_status,
    input  wire logic [2*COORD_WIDTH:0] i_job,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [PIX_W-1:0]     o_pixel_x,
    output logic signed [PIX_W-1:0]     o_pixel_y,
    output logic        [OCT_W-1:0]     o_octant,
    output logic                        o_last
);

    logic signed [COORD_WIDTH-1:0] job_x;
    logic signed [COORD_WIDTH-1:0] job_y;
    logic                          job_fin;

    logic [OCT_W-1:0]        r_oct, n_oct;
    logic                    r_valid;
    logic signed [PIX_W-1:0] r_px, r_py;
    logic [OCT_W-1:0]        r_oct_out;
    logic                    r_last;

    logic                    load;
    logic signed [PIX_W-1:0] off_a, off_b, dx, dy;
    logic signed [PIX_W-1:0] px, py;

    assign {job_x, job_y, job_fin} = i_job;

    assign load  = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign o_pop = load && (r_oct == OCT_LAST);
    assign n_oct = load ? (r_oct + OCT_W'(1)) : r_oct;

    // octant bits: 0 swaps x/y, 1 negates dx, 2 negates dy
    always_comb begin
        off_a = PIX_W'(job_x);
        off_b = PIX_W'(job_y);
        dx    = r_oct[0] ? off_b : off_a;
        dy    = r_oct[0] ? off_a : off_b;
        if (r_oct[1]) begin
            dx = -dx;
        end
        if (r_oct[2]) begin
            dy = -dy;
        end
        px = PIX_W'(i_cfg.center_x) + dx;
        py = PIX_W'(i_cfg.center_y) + dy;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_oct <= n_oct;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px      <= px;
            r_py      <= py;
            r_oct_out <= r_oct;
            r_last    <= job_fin && (r_oct == OCT_LAST);
        end
    end

    assign o_out_valid = r_valid;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_octant    = r_oct_out;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: rtl/core/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer: configuration registers,
// front end, job queue and back end. Depends on mcr_pkg, mcr_front,
// mcr_queue and mcr_back.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_restart
//   out     | output    | o_out_valid / i_out_stall  | o_pixel_x, o_pixel_y, o_octant,
//           |           |                            | o_last
//   cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// An active advance yields eight pixel transfers, one per cycle from the back end's
// output register while i_out_stall is low; a restart or an idle advance is
// handled in the front end alone and queues no job.
// The two-entry job queue lets the front take the next item while pixels drain.
// Reset (synchronous, active low) clears the point, decision, active flag,
// queue and output valid; stride resets to 1, other configuration registers to 0.
`default_nettype none

module midpoint_circle_rasterizer_top
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_restart,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [PIX_W-1:0]    o_pixel_x,
    output logic signed [PIX_W-1:0]    o_pixel_y,
    output logic        [OCT_W-1:0]    o_octant,
    output logic                       o_last
);

    localparam int JOB_W = 2 * COORD_WIDTH + 1;

    t_cfg             r_cfg;
    t_q_status        q_status;
    logic             push;
    logic             pop;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.radius   <= '0;
            r_cfg.stride   <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data[CTR_W-1:0];
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data[CTR_W-1:0];
                REG_RADIUS:   r_cfg.radius   <= i_cfg_data[RAD_W-1:0];
                REG_STRIDE:   r_cfg.stride   <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    mcr_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_restart  (i_restart),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (job_in)
    );

    mcr_queue #(
        .W(JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .i_pop    (pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    mcr_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_octant    (o_octant),
        .o_last      (o_last)
    );

    // the last flag only rides on the final octant
    a_last_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_octant == OCT_LAST))
        else $error("last flag on an octant other than the final one");

    // queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("job queue overflow");

    // a pixel transfer mid-point is followed at once by the next octant
    a_octant_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_octant != OCT_LAST))
        |=> (o_out_valid && (o_octant == $past(o_octant) + OCT_W'(1))))
        else $error("octant sequence broken");

endmodule

`default_nettype wire
